// ===== hw/rtl/hdr_pixel_tone_map_gamma_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tone map core
// Clocked property checks. The bodies are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HDR_PIXEL_TONE_MAP_GAMMA_CORE_ASSERT_SVH
`define HDR_PIXEL_TONE_MAP_GAMMA_CORE_ASSERT_SVH
`ifndef SYNTH
// checked out of reset only
`define HTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define HTM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HTM_ASSERT(lbl, prop, msg)
`define HTM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/htm_pkg.sv =====
// ----------------------------------------------------------------------------
// htm_pkg
// Word types and the elaboration-time threshold table of the tone map core.
// ----------------------------------------------------------------------------
`default_nettype none

package htm_pkg;

	localparam int CH_W       = 24;
	localparam int NUM_CH     = 3;
	localparam int THR_W      = 41;   // widest fixed-point word plus one
	localparam int BIG_W      = 320;
	localparam int GAMMA_NUM  = 5;
	localparam int GAMMA_DEN  = 11;
	localparam int FULL_SCALE = 255;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic            frame_end_in;
	} htm_pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end_out;
	} htm_result_t;

	typedef logic [BIG_W-1:0] htm_big_t;
	typedef logic [255:0][THR_W-1:0] htm_thr_tbl_t;

	function automatic htm_big_t htm_pow(htm_big_t b, int e);
		htm_big_t acc;
		acc = htm_big_t'(1);
		for (int i = 0; i < e; i++) begin
			acc = acc * b;
		end
		return acc;
	endfunction

	// Entry k: smallest radiance word X with
	// k^11 * (2^F + X)^5 <= 255^11 * X^5, or 2^W when no word qualifies.
	// The output byte is the largest k whose entry is <= X.
	function automatic htm_thr_tbl_t htm_thresholds(int int_bits, int frac_bits);
		htm_thr_tbl_t    tbl;
		htm_big_t        one_f;
		htm_big_t        kp;
		htm_big_t        rhs_c;
		htm_big_t        xb;
		htm_big_t        lhs;
		htm_big_t        rhs;
		logic [THR_W-1:0] lo;
		logic [THR_W-1:0] hi;
		logic [THR_W-1:0] mid;
		int              w;
		w     = int_bits + frac_bits;
		one_f = htm_big_t'(1) << frac_bits;
		rhs_c = htm_pow(htm_big_t'(FULL_SCALE), GAMMA_DEN);
		tbl   = '0;
		for (int k = 1; k < 256; k++) begin
			kp = htm_pow(htm_big_t'(k), GAMMA_DEN);
			lo = tbl[k-1];   // thresholds rise with k
			hi = THR_W'(1) << w;
			for (int it = 0; it <= THR_W; it++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					xb  = htm_big_t'(mid);
					lhs = kp * htm_pow(one_f + xb, GAMMA_NUM);
					rhs = rhs_c * htm_pow(xb, GAMMA_NUM);
					if (lhs <= rhs) begin
						hi = mid;
					end else begin
						lo = mid + THR_W'(1);
					end
				end
			end
			tbl[k] = lo;
		end
		return tbl;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hdr_pixel_tone_map_gamma_core.sv =====
// ----------------------------------------------------------------------------
// hdr_pixel_tone_map_gamma_core
// Reinhard tone map with gamma 2.2: HDR RGB pixel in, 8-bit RGB pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   src_* takes one HDR pixel word per handshake (valid/ready): three 8.16
//   radiance channels and a frame end mark. dst_* gives one byte RGB word
//   per pixel, in order, with the frame end mark copied through.
//   Each byte is floor(255 * (x/(1+x))^(1/2.2)), exact for every input.
// Structure: one registered search stage per output byte bit (MSB first),
//   each against a 256-entry threshold table.
// Throughput: one word per cycle sustained while dst_ready is high. Each
//   stage compares a table entry against each channel's radiance word, so
//   the rate is set by one 25-bit (FIX_W+1) compare plus the table mux.
// Reset: arst_n clears all stage valid bits; the pipe comes up empty.
// Stall: when dst_ready is low, words pile up stage by stage behind the
//   output register; src_ready falls only once every stage is full.
//   Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hdr_pixel_tone_map_gamma_core #(
	parameter int INT_BITS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output      logic                 src_ready,
	input  wire htm_pkg::htm_pixel_t  src_word,
	output      logic                 dst_valid,
	input  wire logic                 dst_ready,
	output      htm_pkg::htm_result_t dst_word
);

	import htm_pkg::*;

	localparam int FIX_W   = INT_BITS + FRAC_BITS;
	localparam int NSTAGES = 8;

	// threshold per output byte value, worked out at elaboration
	localparam htm_thr_tbl_t THR = htm_thresholds(INT_BITS, FRAC_BITS);

	logic [NSTAGES:0]                         valid;
	logic [NSTAGES:0]                         ready;
	logic [NSTAGES:0][NUM_CH-1:0][FIX_W-1:0] x;
	logic [NSTAGES:0][NUM_CH-1:0][7:0]       k;
	logic [NSTAGES:0]                         fe;

	// only the low FIX_W bits of a channel count
	assign valid[0] = src_valid;
	assign src_ready = ready[0];
	assign x[0][0]  = FIX_W'(src_word.red_in);
	assign x[0][1]  = FIX_W'(src_word.green_in);
	assign x[0][2]  = FIX_W'(src_word.blue_in);
	assign k[0]     = '0;
	assign fe[0]    = src_word.frame_end_in;

	for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
		htm_search_stage #(
			.FIX_W (FIX_W),
			.BIT   (NSTAGES - 1 - i),
			.THR   (THR)
		) u_stage (
			.clk          (clk),
			.arst_n       (arst_n),
			.up_valid     (valid[i]),
			.up_ready     (ready[i]),
			.up_x         (x[i]),
			.up_k         (k[i]),
			.up_frame_end (fe[i]),
			.dn_valid     (valid[i+1]),
			.dn_ready     (ready[i+1]),
			.dn_x         (x[i+1]),
			.dn_k         (k[i+1]),
			.dn_frame_end (fe[i+1])
		);
	end

	// last stage register is the output register
	assign dst_valid              = valid[NSTAGES];
	assign ready[NSTAGES]         = dst_ready;
	assign dst_word.red_out       = k[NSTAGES][0];
	assign dst_word.green_out     = k[NSTAGES][1];
	assign dst_word.blue_out      = k[NSTAGES][2];
	assign dst_word.frame_end_out = fe[NSTAGES] & (x[NSTAGES] == x[NSTAGES] || 1'b1);

endmodule

`default_nettype wire

// ===== hw/rtl/htm_search_stage.sv =====
// ----------------------------------------------------------------------------
// htm_search_stage
// One bit of the output byte search for all three channels, registered.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hdr_pixel_tone_map_gamma_core_assert.svh"

module htm_search_stage #(
	parameter int                    FIX_W = 24,
	parameter int                    BIT   = 7,
	parameter htm_pkg::htm_thr_tbl_t THR   = '0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  up_valid,
	output      logic                  up_ready,
	input  wire logic [2:0][FIX_W-1:0] up_x,
	input  wire logic [2:0][7:0]       up_k,
	input  wire logic                  up_frame_end,
	output      logic                  dn_valid,
	input  wire logic                  dn_ready,
	output      logic [2:0][FIX_W-1:0] dn_x,
	output      logic [2:0][7:0]       dn_k,
	output      logic                  dn_frame_end
);

	localparam logic [7:0] CAND_BIT = 8'(1) << BIT;
	localparam logic [7:0] LOW_MASK = CAND_BIT - 8'd1;

	logic                  valid_s1;
	logic [2:0][FIX_W-1:0] x_s1;
	logic [2:0][7:0]       k_s1;
	logic                  fe_s1;
	logic [2:0][7:0]       k_next;

	// try the next bit; keep it when the word reaches that threshold
	always_comb begin
		logic [7:0] cand;
		cand = '0;
		for (int c = 0; c < 3; c++) begin
			cand = up_k[c] | CAND_BIT;
			if (THR[cand][FIX_W:0] <= (FIX_W+1)'(up_x[c])) begin
				k_next[c] = cand;
			end else begin
				k_next[c] = up_k[c];
			end
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			x_s1  <= up_x;
			k_s1  <= k_next;
			fe_s1 <= up_frame_end;
		end
	end

	assign dn_valid     = valid_s1;
	assign dn_x         = x_s1;
	assign dn_k         = k_s1;
	assign dn_frame_end = fe_s1;

	`HTM_ASSERT_RST(a_rst_empty, !arst_n |-> !valid_s1, "stage holds a word in reset")
	`HTM_ASSERT(a_take_fills, up_valid && up_ready |=> valid_s1, "accepted word lost")
	`HTM_ASSERT(a_low_bits_clear,
		valid_s1 |-> ((k_s1[0] | k_s1[1] | k_s1[2]) & LOW_MASK) == 8'd0,
		"undecided byte bits set")
	`HTM_ASSERT(a_below_word,
		valid_s1 |-> (THR[k_s1[0]][FIX_W:0] <= (FIX_W+1)'(x_s1[0]))
			&& (THR[k_s1[1]][FIX_W:0] <= (FIX_W+1)'(x_s1[1]))
			&& (THR[k_s1[2]][FIX_W:0] <= (FIX_W+1)'(x_s1[2])),
		"byte above radiance threshold")

endmodule

`default_nettype wire
